/* rtl/core/drvfp_pkg.sv */
// Shared types and constants of the drive reply VX/PX field parser.
// Character codes, header limits and field slot flag type.
// Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package drvfp_pkg;

   localparam logic [7:0] CH_V     = 8'h56;
   localparam logic [7:0] CH_X     = 8'h58;
   localparam logic [7:0] CH_P     = 8'h50;
   localparam logic [7:0] CH_SEMI  = 8'h3B;
   localparam logic [7:0] CH_MINUS = 8'h2D;
   localparam logic [7:0] CH_ZERO  = 8'h30;
   localparam logic [7:0] CH_NINE  = 8'h39;

   localparam logic [1:0] MAX_HEADERS = 2'd2;

   localparam int unsigned MAX_FIELD_CHARS_DEFAULT = 31;

   localparam int unsigned NUM_SLOTS = 2;

   typedef enum logic [1:0] {
      LETTER_NONE,
      LETTER_V,
      LETTER_P
   } letter_type;

   typedef enum logic {
      KIND_VX,
      KIND_PX
   } kind_type;

   typedef struct packed {
      logic     active;
      kind_type kind;
      logic     skip_pending;
      logic     bad;
      logic     negative;
      logic     stopped;
   } slot_flags_type;

endpackage

`default_nettype wire

/* rtl/core/drive_reply_vx_px_field_parser.sv */
// Top level of the drive reply VX/PX field parser.
// Input register, per-byte parse logic, two field slots and result register.
// Depends on drvfp_pkg.
`timescale 1ns / 1ps
`default_nettype none

// Takes one byte of a motor drive's serial reply per request and returns exactly one
// result per byte. Within a poll frame (closed by a byte with frame_end set) the first
// two "VX" or "PX" headers each open a field after one skipped byte; the field runs to
// ';'. A field made only of digits and '-', at most MAX_FIELD_CHARS long, is converted
// (optional leading '-', digits up to the next '-', wrapping at 32 bits) and stored:
// VX into the 16-bit velocity reading (low bits), PX into the 32-bit position reading.
// Rate: one request per cycle while the receiver does not stall; a request's result
// passes the input register, then the result register. The per-byte path is one
// multiply-by-ten add per slot in parallel plus the store selection. The stored
// readings reset to zero; frame tracking returns to its reset state after every frame.
module drive_reply_vx_px_field_parser #(
   parameter int unsigned MAX_FIELD_CHARS = drvfp_pkg::MAX_FIELD_CHARS_DEFAULT
) (
   input  wire                clock,
   input  wire                reset,
   input  wire                req_valid,
   output logic               req_stall,
   input  wire  [7:0]         req_rx_byte,
   input  wire                req_frame_end,
   output logic               rsp_valid,
   input  wire                rsp_stall,
   output logic               rsp_vel_closed,
   output logic               rsp_vel_accepted,
   output logic               rsp_pos_closed,
   output logic               rsp_pos_accepted,
   output logic signed [15:0] rsp_velocity_out,
   output logic signed [31:0] rsp_position_out
);

   localparam int unsigned CNT_W = $clog2(MAX_FIELD_CHARS + 1);
   localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_FIELD_CHARS);
   localparam int unsigned SLOTS = drvfp_pkg::NUM_SLOTS;

   // Input register.
   logic       in_valid_ff;
   logic [7:0] in_byte_ff;
   logic       in_end_ff;

   // Result register (flags only; the readings are the state registers themselves).
   logic rsp_valid_ff;
   logic vel_closed_ff, vel_ok_ff, pos_closed_ff, pos_ok_ff;

   // Parse state.
   logic [15:0]              vel_ff, vel_in;
   logic [31:0]              pos_ff, pos_in;
   drvfp_pkg::letter_type    prev_ff, prev_in;
   logic [1:0]               taken_ff, taken_in;
   drvfp_pkg::slot_flags_type flags_ff [SLOTS];
   drvfp_pkg::slot_flags_type flags_in [SLOTS];
   logic [CNT_W-1:0]         cnt_ff [SLOTS];
   logic [CNT_W-1:0]         cnt_in [SLOTS];
   logic [31:0]              acc_ff [SLOTS];
   logic [31:0]              acc_in [SLOTS];

   // Per-slot outcome of the current byte.
   drvfp_pkg::slot_flags_type fed_flags [SLOTS];
   logic [CNT_W-1:0]         fed_cnt [SLOTS];
   logic [31:0]              fed_acc [SLOTS];
   logic [SLOTS-1:0]         slot_closed;
   logic [SLOTS-1:0]         slot_ok;
   logic [31:0]              slot_val [SLOTS];

   logic advance;
   logic out_free;
   logic is_digit;
   logic hdr_hit;
   logic vel_closed_in, vel_ok_in, pos_closed_in, pos_ok_in;

   // Advance the input stage whenever the result register is empty or being drained.
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign advance   = in_valid_ff && out_free;
   assign req_stall = in_valid_ff && !out_free;

   assign is_digit = (in_byte_ff >= drvfp_pkg::CH_ZERO) && (in_byte_ff <= drvfp_pkg::CH_NINE);

   // Feed the byte to both open slots; they work independently.
   always_comb begin
      for (int i = 0; i < SLOTS; i++) begin
         fed_flags[i]   = flags_ff[i];
         fed_cnt[i]     = cnt_ff[i];
         fed_acc[i]     = acc_ff[i];
         slot_closed[i] = 1'b0;
         slot_ok[i]     = 1'b0;
         slot_val[i]    = flags_ff[i].negative ? (~acc_ff[i] + 32'd1) : acc_ff[i];
         if (flags_ff[i].active) begin
            if (flags_ff[i].skip_pending) begin
               // Drop the byte right after the header untested.
               fed_flags[i].skip_pending = 1'b0;
            end else if (in_byte_ff == drvfp_pkg::CH_SEMI) begin
               slot_closed[i] = 1'b1;
               slot_ok[i]     = !flags_ff[i].bad;
               fed_flags[i]   = '0;
               fed_cnt[i]     = '0;
               fed_acc[i]     = '0;
            end else begin
               if (cnt_ff[i] >= MAX_CNT) begin
                  fed_flags[i].bad = 1'b1;
               end else begin
                  fed_cnt[i] = cnt_ff[i] + CNT_W'(1);
               end
               if (in_byte_ff == drvfp_pkg::CH_MINUS) begin
                  if (cnt_ff[i] == '0) begin
                     fed_flags[i].negative = 1'b1;
                  end else begin
                     fed_flags[i].stopped = 1'b1;
                  end
               end else if (is_digit) begin
                  if (!flags_ff[i].stopped) begin
                     fed_acc[i] = (acc_ff[i] << 3) + (acc_ff[i] << 1)
                                + {28'd0, in_byte_ff[3:0]};
                  end
               end else begin
                  fed_flags[i].bad = 1'b1;
               end
            end
         end
      end
   end

   // Combine slots, open new fields, track headers and close the frame.
   always_comb begin
      vel_closed_in = 1'b0;
      vel_ok_in     = 1'b0;
      pos_closed_in = 1'b0;
      pos_ok_in     = 1'b0;
      vel_in        = vel_ff;
      pos_in        = pos_ff;
      // Older slot first, so a later accepted field of the same kind wins.
      for (int i = 0; i < SLOTS; i++) begin
         if (flags_ff[i].kind == drvfp_pkg::KIND_VX) begin
            vel_closed_in = vel_closed_in | slot_closed[i];
            vel_ok_in     = vel_ok_in | slot_ok[i];
            if (slot_ok[i]) begin
               vel_in = slot_val[i][15:0];
            end
         end else begin
            pos_closed_in = pos_closed_in | slot_closed[i];
            pos_ok_in     = pos_ok_in | slot_ok[i];
            if (slot_ok[i]) begin
               pos_in = slot_val[i];
            end
         end
      end

      for (int i = 0; i < SLOTS; i++) begin
         flags_in[i] = fed_flags[i];
         cnt_in[i]   = fed_cnt[i];
         acc_in[i]   = fed_acc[i];
      end

      hdr_hit  = (in_byte_ff == drvfp_pkg::CH_X) && (prev_ff != drvfp_pkg::LETTER_NONE)
               && (taken_ff < drvfp_pkg::MAX_HEADERS);
      taken_in = taken_ff;
      if (hdr_hit) begin
         flags_in[taken_ff[0]]              = '0;
         flags_in[taken_ff[0]].active       = 1'b1;
         flags_in[taken_ff[0]].kind         = (prev_ff == drvfp_pkg::LETTER_V)
                                            ? drvfp_pkg::KIND_VX : drvfp_pkg::KIND_PX;
         flags_in[taken_ff[0]].skip_pending = 1'b1;
         cnt_in[taken_ff[0]]                = '0;
         acc_in[taken_ff[0]]                = '0;
         taken_in                           = taken_ff + 2'd1;
      end

      priority if (in_byte_ff == drvfp_pkg::CH_V) begin
         prev_in = drvfp_pkg::LETTER_V;
      end else if (in_byte_ff == drvfp_pkg::CH_P) begin
         prev_in = drvfp_pkg::LETTER_P;
      end else begin
         prev_in = drvfp_pkg::LETTER_NONE;
      end

      // Frame end: drop open fields and header tracking, keep the readings.
      if (in_end_ff) begin
         prev_in  = drvfp_pkg::LETTER_NONE;
         taken_in = '0;
         for (int i = 0; i < SLOTS; i++) begin
            flags_in[i] = '0;
            cnt_in[i]   = '0;
            acc_in[i]   = '0;
         end
      end
   end

   // Control and state registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         vel_ff       <= '0;
         pos_ff       <= '0;
         prev_ff      <= drvfp_pkg::LETTER_NONE;
         taken_ff     <= '0;
         for (int i = 0; i < SLOTS; i++) begin
            flags_ff[i] <= '0;
            cnt_ff[i]   <= '0;
            acc_ff[i]   <= '0;
         end
      end else begin
         if (!req_stall) begin
            in_valid_ff <= req_valid;
         end
         if (out_free) begin
            rsp_valid_ff <= in_valid_ff;
         end
         if (advance) begin
            vel_ff   <= vel_in;
            pos_ff   <= pos_in;
            prev_ff  <= prev_in;
            taken_ff <= taken_in;
            for (int i = 0; i < SLOTS; i++) begin
               flags_ff[i] <= flags_in[i];
               cnt_ff[i]   <= cnt_in[i];
               acc_ff[i]   <= acc_in[i];
            end
         end
      end
   end

   // Payload registers: hold while stalled.
   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         in_byte_ff <= req_rx_byte;
         in_end_ff  <= req_frame_end;
      end
      if (advance) begin
         vel_closed_ff <= vel_closed_in;
         vel_ok_ff     <= vel_ok_in;
         pos_closed_ff <= pos_closed_in;
         pos_ok_ff     <= pos_ok_in;
      end
   end

   // The readings change only when a new result loads, so they double as its payload.
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_vel_closed   = vel_closed_ff;
   assign rsp_vel_accepted = vel_ok_ff;
   assign rsp_pos_closed   = pos_closed_ff;
   assign rsp_pos_accepted = pos_ok_ff;
   assign rsp_velocity_out = $signed(vel_ff);
   assign rsp_position_out = $signed(pos_ff);

`ifndef SYNTHESIS
   a_accept_needs_close: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> ((!vel_ok_ff || vel_closed_ff) && (!pos_ok_ff || pos_closed_ff)))
      else $error("accepted flag without a closed field");

   a_header_limit: assert property (@(posedge clock) disable iff (reset)
      taken_ff <= drvfp_pkg::MAX_HEADERS)
      else $error("more headers taken than allowed");

   a_frame_end_clears: assert property (@(posedge clock) disable iff (reset)
      (advance && in_end_ff) |=> (taken_ff == '0 && !flags_ff[0].active
                                  && !flags_ff[1].active))
      else $error("frame state not cleared at frame end");

   a_reading_hold: assert property (@(posedge clock) disable iff (reset)
      !advance |=> ($stable(vel_ff) && $stable(pos_ff)))
      else $error("reading changed without a request");
`endif

endmodule

`default_nettype wire

/* sim/testbench.sv */
// Self-checking bench for the drive reply VX/PX field parser.
// Predicts each reply from the request bytes and compares every field; needs drvfp_pkg
// and drive_reply_vx_px_field_parser.
`timescale 1ns / 1ps

module testbench;

   localparam int unsigned FIELD_LIMIT = drvfp_pkg::MAX_FIELD_CHARS_DEFAULT;
   localparam int          RANDOM_BYTES = 1400;
   localparam int          CYCLE_LIMIT = 200000;
   localparam int          HOLD_CYCLES = 200;

   // One reply of the parser as seen on the result channel.
   typedef struct {
      logic        vel_closed;
      logic        vel_accepted;
      logic        pos_closed;
      logic        pos_accepted;
      logic [15:0] velocity;
      logic [31:0] position;
   } parser_reply_type;

   // Running state of one open field.
   typedef struct {
      drvfp_pkg::slot_flags_type flags;
      logic [5:0]                count;
      logic [31:0]               accum;
   } field_slot_type;

   // Tracks headers, field slots and stored readings, and queues the reply that
   // each accepted request byte must produce.
   class parser_scoreboard;
      logic [15:0]           velocity;
      logic [31:0]           position;
      drvfp_pkg::letter_type prev_letter;
      logic [1:0]            headers_taken;
      field_slot_type        slots[drvfp_pkg::NUM_SLOTS];
      logic                  closed[2];
      logic                  accepted[2];
      parser_reply_type      expected_replies[$];
      int                    errors;

      function new();
         velocity = '0;
         position = '0;
         errors = 0;
         clear_frame();
      endfunction

      function void clear_slot(int i);
         slots[i].flags = '0;
         slots[i].count = '0;
         slots[i].accum = '0;
      endfunction

      function void clear_frame();
         prev_letter = drvfp_pkg::LETTER_NONE;
         headers_taken = '0;
         for (int i = 0; i < drvfp_pkg::NUM_SLOTS; i++) clear_slot(i);
      endfunction

      function void feed_slot(int i, logic [7:0] b);
         logic [5:0]  pos;
         logic [31:0] value;
         if (!slots[i].flags.active) return;
         if (slots[i].flags.skip_pending) begin
            slots[i].flags.skip_pending = 1'b0;
            return;
         end
         if (b == drvfp_pkg::CH_SEMI) begin
            closed[slots[i].flags.kind] = 1'b1;
            if (!slots[i].flags.bad) begin
               value = slots[i].flags.negative ? 32'd0 - slots[i].accum : slots[i].accum;
               accepted[slots[i].flags.kind] = 1'b1;
               if (slots[i].flags.kind == drvfp_pkg::KIND_VX) velocity = value[15:0];
               else position = value;
            end
            clear_slot(i);
            return;
         end
         pos = slots[i].count;
         if (pos >= FIELD_LIMIT) slots[i].flags.bad = 1'b1;
         else slots[i].count = pos + 6'd1;
         if (b == drvfp_pkg::CH_MINUS) begin
            // only a leading minus is a sign; any later one ends the number
            if (pos == 0) slots[i].flags.negative = 1'b1;
            else slots[i].flags.stopped = 1'b1;
         end else if (b >= drvfp_pkg::CH_ZERO && b <= drvfp_pkg::CH_NINE) begin
            if (!slots[i].flags.stopped)
               slots[i].accum = slots[i].accum * 32'd10 + 32'(b - drvfp_pkg::CH_ZERO);
         end else begin
            slots[i].flags.bad = 1'b1;
         end
      endfunction

      function void note_byte(logic [7:0] b, logic last);
         parser_reply_type reply;
         int               k;
         closed[0] = 1'b0;
         closed[1] = 1'b0;
         accepted[0] = 1'b0;
         accepted[1] = 1'b0;
         // older slot first, so a later store of the same kind wins
         feed_slot(0, b);
         feed_slot(1, b);
         if (b == drvfp_pkg::CH_X && prev_letter != drvfp_pkg::LETTER_NONE
             && headers_taken < drvfp_pkg::MAX_HEADERS) begin
            k = headers_taken[0];
            clear_slot(k);
            slots[k].flags.active = 1'b1;
            if (prev_letter == drvfp_pkg::LETTER_V) slots[k].flags.kind = drvfp_pkg::KIND_VX;
            else slots[k].flags.kind = drvfp_pkg::KIND_PX;
            slots[k].flags.skip_pending = 1'b1;
            headers_taken = headers_taken + 2'd1;
         end
         if (b == drvfp_pkg::CH_V) prev_letter = drvfp_pkg::LETTER_V;
         else if (b == drvfp_pkg::CH_P) prev_letter = drvfp_pkg::LETTER_P;
         else prev_letter = drvfp_pkg::LETTER_NONE;
         if (last) clear_frame();
         reply.vel_closed = closed[drvfp_pkg::KIND_VX];
         reply.vel_accepted = accepted[drvfp_pkg::KIND_VX];
         reply.pos_closed = closed[drvfp_pkg::KIND_PX];
         reply.pos_accepted = accepted[drvfp_pkg::KIND_PX];
         reply.velocity = velocity;
         reply.position = position;
         expected_replies.push_back(reply);
      endfunction

      function void compare_field(string name, logic [31:0] want, logic [31:0] got);
         if (got !== want) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            errors++;
         end
      endfunction

      function void check_reply(parser_reply_type got);
         parser_reply_type want;
         if (expected_replies.size() == 0) begin
            $error("reply arrived with no request outstanding");
            errors++;
            return;
         end
         want = expected_replies.pop_front();
         compare_field("vel_closed", want.vel_closed, got.vel_closed);
         compare_field("vel_accepted", want.vel_accepted, got.vel_accepted);
         compare_field("pos_closed", want.pos_closed, got.pos_closed);
         compare_field("pos_accepted", want.pos_accepted, got.pos_accepted);
         compare_field("velocity_out", want.velocity, got.velocity);
         compare_field("position_out", want.position, got.position);
      endfunction

      function int pending();
         return expected_replies.size();
      endfunction
   endclass

   logic               clock;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_stall;
   logic [7:0]         req_rx_byte = 8'h00;
   logic               req_frame_end = 1'b0;
   logic               rsp_valid;
   logic               rsp_stall = 1'b0;
   logic               rsp_vel_closed;
   logic               rsp_vel_accepted;
   logic               rsp_pos_closed;
   logic               rsp_pos_accepted;
   logic signed [15:0] rsp_velocity_out;
   logic signed [31:0] rsp_position_out;

   parser_scoreboard   sb = new();
   parser_reply_type   reply_seen;
   logic [7:0]         frame_q[$];

   // idle odds in percent for each side
   int                 req_idle_pct = 0;
   int                 rsp_idle_pct = 0;

   // long receiver hold-offs: the stimulus bumps hold_asked, the receiver serves them
   int                 hold_asked = 0;
   int                 hold_done = 0;
   int                 hold_left = 0;
   int                 cycle_count = 0;

   drive_reply_vx_px_field_parser #(
      .MAX_FIELD_CHARS(FIELD_LIMIT)
   ) dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_rx_byte     (req_rx_byte),
      .req_frame_end   (req_frame_end),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_vel_closed  (rsp_vel_closed),
      .rsp_vel_accepted(rsp_vel_accepted),
      .rsp_pos_closed  (rsp_pos_closed),
      .rsp_pos_accepted(rsp_pos_accepted),
      .rsp_velocity_out(rsp_velocity_out),
      .rsp_position_out(rsp_position_out)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // Watchdog: end the run as failed if it has not finished by the cycle limit.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("testbench failed");
         $finish;
      end
   end

   // Receiver: serve a pending long hold-off first, otherwise stall at random.
   always @(posedge clock) begin
      if (hold_left > 0) begin
         rsp_stall <= 1'b1;
         hold_left <= hold_left - 1;
      end else if (hold_done != hold_asked) begin
         rsp_stall <= 1'b1;
         hold_done <= hold_done + 1;
         hold_left <= HOLD_CYCLES;
      end else begin
         rsp_stall <= ($urandom_range(99) < rsp_idle_pct);
      end
   end

   // Monitor: note each accepted request before checking the reply of the same edge;
   // a reply always comes after its request.
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && !req_stall) sb.note_byte(req_rx_byte, req_frame_end);
         if (rsp_valid && !rsp_stall) begin
            reply_seen.vel_closed = rsp_vel_closed;
            reply_seen.vel_accepted = rsp_vel_accepted;
            reply_seen.pos_closed = rsp_pos_closed;
            reply_seen.pos_accepted = rsp_pos_accepted;
            reply_seen.velocity = rsp_velocity_out;
            reply_seen.position = rsp_position_out;
            sb.check_reply(reply_seen);
         end
      end
   end

   // Offer one request and hold it until taken; then idle each cycle at the sender's odds.
   // Valid is not lowered when no gap follows, so the next request keeps it high.
   task automatic send_byte(input logic [7:0] b, input logic last);
      req_valid <= 1'b1;
      req_rx_byte <= b;
      req_frame_end <= last;
      do @(posedge clock); while (req_stall);
      if ($urandom_range(99) < req_idle_pct) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < req_idle_pct);
      end
   endtask

   // Send a whole poll frame; the last byte carries the frame end mark.
   task automatic send_frame();
      for (int i = 0; i < frame_q.size(); i++)
         send_byte(frame_q[i], i == frame_q.size() - 1);
   endtask

   task automatic send_text(input string s);
      frame_q.delete();
      for (int i = 0; i < s.len(); i++) frame_q.push_back(s[i]);
      send_frame();
   endtask

   // Pause the sender until every outstanding reply has come back; always step the
   // clock first so the monitor has noted the last request.
   task automatic wait_for_replies();
      req_valid <= 1'b0;
      do @(posedge clock); while (sb.pending() != 0);
   endtask

   // Field text: optional sign, mostly short digit runs, now and then one past the
   // length limit, a stray minus that ends the number, or a byte that spoils it.
   function automatic void add_field_text();
      int len;
      int pick;
      int bad_at;
      int stop_at;
      pick = $urandom_range(99);
      if (pick < 85) len = $urandom_range(10);
      else if (pick < 95) len = $urandom_range(31, 11);
      else len = $urandom_range(36, 30);
      bad_at = ($urandom_range(99) < 10) ? $urandom_range(len) : -1;
      stop_at = ($urandom_range(99) < 10) ? $urandom_range(len) : -1;
      if ($urandom_range(99) < 30) frame_q.push_back(drvfp_pkg::CH_MINUS);
      for (int i = 0; i < len; i++) begin
         if (i == bad_at) frame_q.push_back(8'($urandom_range(255)));
         else if (i == stop_at) frame_q.push_back(drvfp_pkg::CH_MINUS);
         else frame_q.push_back(8'(drvfp_pkg::CH_ZERO + $urandom_range(9)));
      end
   endfunction

   // Build one random frame: mostly one to three headed fields with random
   // content, else plain noise; sometimes a header dangles at the frame end.
   function automatic void build_frame();
      int pick;
      frame_q.delete();
      pick = $urandom_range(99);
      if (pick < 8) begin
         repeat ($urandom_range(12, 1)) frame_q.push_back(8'($urandom_range(255)));
         return;
      end
      repeat ($urandom_range(3, 1)) begin
         if ($urandom_range(99) < 30)
            repeat ($urandom_range(3, 1))
               frame_q.push_back($urandom_range(1) ? 8'h20 : 8'($urandom_range(255)));
         frame_q.push_back($urandom_range(1) ? drvfp_pkg::CH_V : drvfp_pkg::CH_P);
         frame_q.push_back(drvfp_pkg::CH_X);
         frame_q.push_back(8'($urandom_range(255)));
         add_field_text();
         if ($urandom_range(99) < 92) frame_q.push_back(drvfp_pkg::CH_SEMI);
      end
      pick = $urandom_range(99);
      if (pick < 5) begin
         frame_q.push_back($urandom_range(1) ? drvfp_pkg::CH_V : drvfp_pkg::CH_P);
         frame_q.push_back(drvfp_pkg::CH_X);
      end else if (pick < 25) begin
         frame_q.push_back(8'($urandom_range(255)));
      end
   endfunction

   initial begin
      int  random_bytes;
      int  phase;
      bit  held;
      random_bytes = 0;
      phase = 0;
      held = 1'b0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // Phase one: sender rarely idles, receiver stalls most of the time.
      req_idle_pct = 6;
      rsp_idle_pct <= 63;

      // Directed frames:
      // skipped ';', leading minus, minus that stops the number, bare sign,
      // third header ignored; then both slots closing on one byte with an empty
      // field; then the byte extremes and a header on the last byte.
      send_text("PX;-7-3;VX:-;PX5;");
      send_text("VX,5PX,;");
      send_byte(8'h00, 1'b0);
      send_byte(8'hFF, 1'b1);
      send_text("VX");

      while (random_bytes < RANDOM_BYTES) begin
         if (phase == 0 && random_bytes >= RANDOM_BYTES / 3) begin
            // swap roles: sender idles often, receiver rarely
            wait_for_replies();
            phase = 1;
            req_idle_pct = 63;
            rsp_idle_pct <= 6;
         end else if (phase == 1 && random_bytes >= 2 * RANDOM_BYTES / 3) begin
            // no idling on either side; start with a long hold-off to fill the block
            wait_for_replies();
            phase = 2;
            req_idle_pct = 0;
            rsp_idle_pct <= 0;
            hold_asked <= hold_asked + 1;
         end else if (phase == 0 && !held && random_bytes >= 200) begin
            held = 1'b1;
            hold_asked <= hold_asked + 1;
         end
         build_frame();
         random_bytes += frame_q.size();
         send_frame();
      end

      wait_for_replies();
      repeat (10) @(posedge clock);
      if (sb.errors == 0 && sb.pending() == 0)
         $display("testbench passed");
      else
         $display("testbench failed");
      $finish;
   end

endmodule
